// ===== rtl/vmb_pkg.sv =====
// vmb_pkg: types, register offsets and helper functions shared by the
// virtio-mmio block device register front end.
// No dependencies.
package vmb_pkg;

    // Sizing of the virtqueue and the host bus
    localparam int QUEUE_MAX = 8;
    localparam int QSZ_W     = $clog2(QUEUE_MAX + 1);
    localparam int BUS_BYTES = 8;
    localparam int BUS_W     = BUS_BYTES * 8;
    localparam int LANE_SEL_W = $clog2(BUS_BYTES);
    localparam logic [63:0] BUS_MASK = (BUS_W == 64) ? 64'hffff_ffff_ffff_ffff
                                                    : ((64'd1 << BUS_W) - 64'd1);

    // Identification words
    localparam logic [31:0] MAGIC_WORD   = 32'h7472_6976;
    localparam logic [31:0] VENDOR_WORD  = 32'h554d_4551;
    localparam logic [31:0] VERSION_WORD = 32'd2;
    localparam logic [31:0] DEVICE_ID    = 32'd2;
    localparam int          SECTOR_SHIFT = 9;   // 512-byte sectors
    localparam int          DISK_W       = 48;

    // Config port: one register, 48 bits wide on a 64-bit bus, at byte address 0
    localparam int          CFG_ADDR_W     = 4;
    localparam logic        CFG_DISK_BYTES = 1'b0;

    // Register window offsets
    localparam logic [11:0] OFS_MAGIC       = 12'h000;
    localparam logic [11:0] OFS_VERSION     = 12'h004;
    localparam logic [11:0] OFS_DEVICE_ID   = 12'h008;
    localparam logic [11:0] OFS_VENDOR      = 12'h00c;
    localparam logic [11:0] OFS_DEV_FEAT    = 12'h010;
    localparam logic [11:0] OFS_DEV_FSEL    = 12'h014;
    localparam logic [11:0] OFS_DRV_FEAT    = 12'h020;
    localparam logic [11:0] OFS_DRV_FSEL    = 12'h024;
    localparam logic [11:0] OFS_QUEUE_SEL   = 12'h030;
    localparam logic [11:0] OFS_QUEUE_MAX   = 12'h034;
    localparam logic [11:0] OFS_QUEUE_NUM   = 12'h038;
    localparam logic [11:0] OFS_QUEUE_READY = 12'h044;
    localparam logic [11:0] OFS_NOTIFY      = 12'h050;
    localparam logic [11:0] OFS_IRQ_STATUS  = 12'h060;
    localparam logic [11:0] OFS_IRQ_ACK     = 12'h064;
    localparam logic [11:0] OFS_STATUS      = 12'h070;
    localparam logic [11:0] OFS_DESC_LO     = 12'h080;
    localparam logic [11:0] OFS_DESC_HI     = 12'h084;
    localparam logic [11:0] OFS_AVAIL_LO    = 12'h090;
    localparam logic [11:0] OFS_AVAIL_HI    = 12'h094;
    localparam logic [11:0] OFS_USED_LO     = 12'h0a0;
    localparam logic [11:0] OFS_USED_HI     = 12'h0a4;
    localparam logic [11:0] OFS_CAP_LO      = 12'h100;
    localparam logic [11:0] OFS_CAP_HI      = 12'h104;

    localparam int STATUS_DRIVER_OK = 2;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_DONE  = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef struct packed {
        func_t       func;
        logic [11:0] offset;
        logic [7:0]  write_byte;
    } in_item_t;

    typedef struct packed {
        logic [63:0] read_data;
        logic        notify_request;
        logic [3:0]  queue_size;
        logic        irq_raise;
    } out_item_t;

    // Replace one byte lane of a 32-bit word
    function automatic logic [31:0] lane32(logic [31:0] old, logic [1:0] lane,
                                           logic [7:0] wbyte);
        logic [31:0] mask;
        mask = 32'hff << {lane, 3'b000};
        return (old & ~mask) | ({24'd0, wbyte} << {lane, 3'b000});
    endfunction

    // Replace one byte lane of a 64-bit word
    function automatic logic [63:0] lane64(logic [63:0] old, logic [2:0] idx,
                                           logic [7:0] wbyte);
        logic [63:0] mask;
        mask = 64'hff << {idx, 3'b000};
        return (old & ~mask) | ({56'd0, wbyte} << {idx, 3'b000});
    endfunction

endpackage

// ===== rtl/vmb_cfg.sv =====
// vmb_cfg: APB-style configuration port holding the disk size register.
// Depends on vmb_pkg.
module vmb_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vmb_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [63:0]                    pwdata,
    output logic [63:0]                    prdata,
    output logic                           pready,
    output logic [vmb_pkg::DISK_W-1:0]     disk_bytes
);

    logic [vmb_pkg::DISK_W-1:0] disk_bytes_reg;
    logic                       hit;
    logic                       wr_en;

    // Register index is address bit 3 (8-byte spacing)
    assign hit    = (paddr[3] == vmb_pkg::CFG_DISK_BYTES);
    assign wr_en  = psel && penable && pwrite && hit;
    assign pready = 1'b1;
    assign prdata = hit ? {{(64 - vmb_pkg::DISK_W){1'b0}}, disk_bytes_reg} : 64'd0;
    assign disk_bytes = disk_bytes_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disk_bytes_reg <= '0;
        end else if (wr_en) begin
            disk_bytes_reg <= pwdata[vmb_pkg::DISK_W-1:0];
        end
    end

endmodule

// ===== rtl/vmb_core.sv =====
// vmb_core: virtio-mmio register state, address decode and byte-lane update.
// One item is processed per enabled cycle. Depends on vmb_pkg.
module vmb_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       item_en,
    input  vmb_pkg::in_item_t          item,
    input  logic [vmb_pkg::DISK_W-1:0] disk_bytes,
    output vmb_pkg::out_item_t         result
);

    logic [31:0]               dev_fsel_reg, dev_fsel_next;
    logic [31:0]               drv_fsel_reg, drv_fsel_next;
    logic [31:0]               drv_feat_reg [2];
    logic [31:0]               drv_feat_next [2];
    logic [31:0]               qsel_reg, qsel_next;
    logic [vmb_pkg::QSZ_W-1:0] qsize_reg, qsize_next;
    logic                      qready_reg, qready_next;
    logic [31:0]               status_reg, status_next;
    logic                      irq_reg, irq_next;
    logic [63:0]               desc_reg, desc_next;
    logic [63:0]               avail_reg, avail_next;
    logic [63:0]               used_reg, used_next;

    logic [11:0]  base;
    logic [1:0]   lane;
    logic         present;
    logic [vmb_pkg::DISK_W-vmb_pkg::SECTOR_SHIFT-1:0] sectors;
    logic         usable;
    logic [31:0]  word;
    logic [31:0]  qsize_merged;
    logic [63:0]  rdata;
    logic         notify;
    logic         irq_out;
    logic         status_wr;

    assign base    = {item.offset[11:2], 2'b00};
    assign lane    = item.offset[1:0];
    assign present = (disk_bytes != '0);
    assign sectors = disk_bytes[vmb_pkg::DISK_W-1:vmb_pkg::SECTOR_SHIFT];

    assign usable = present && (qsel_reg == 32'd0) && qready_reg &&
                    status_reg[vmb_pkg::STATUS_DRIVER_OK] &&
                    (desc_reg != 64'd0) && (avail_reg != 64'd0) && (used_reg != 64'd0);

    // Read decode
    always_comb begin
        word = 32'd0;
        unique case (base)
            vmb_pkg::OFS_MAGIC:       word = vmb_pkg::MAGIC_WORD;
            vmb_pkg::OFS_VERSION:     word = vmb_pkg::VERSION_WORD;
            vmb_pkg::OFS_VENDOR:      word = vmb_pkg::VENDOR_WORD;
            vmb_pkg::OFS_DEVICE_ID:   word = present ? vmb_pkg::DEVICE_ID : 32'd0;
            vmb_pkg::OFS_QUEUE_MAX:   word = (present && qsel_reg == 32'd0) ?
                                             32'(vmb_pkg::QUEUE_MAX) : 32'd0;
            vmb_pkg::OFS_QUEUE_READY: word = present ? {31'd0, qready_reg} : 32'd0;
            vmb_pkg::OFS_IRQ_STATUS:  word = present ? {31'd0, irq_reg} : 32'd0;
            vmb_pkg::OFS_STATUS:      word = present ? status_reg : 32'd0;
            vmb_pkg::OFS_CAP_LO:      word = sectors[31:0];
            vmb_pkg::OFS_CAP_HI:      word = 32'(sectors >> 32);
            default:                  word = 32'd0;
        endcase
    end

    // Queue size: merge the lane, then clamp to the maximum
    assign qsize_merged = vmb_pkg::lane32(32'(qsize_reg), lane, item.write_byte);

    // Write decode and next state
    always_comb begin
        dev_fsel_next    = dev_fsel_reg;
        drv_fsel_next    = drv_fsel_reg;
        drv_feat_next[0] = drv_feat_reg[0];
        drv_feat_next[1] = drv_feat_reg[1];
        qsel_next        = qsel_reg;
        qsize_next       = qsize_reg;
        qready_next      = qready_reg;
        status_next      = status_reg;
        irq_next         = irq_reg;
        desc_next        = desc_reg;
        avail_next       = avail_reg;
        used_next        = used_reg;
        rdata            = 64'd0;
        notify           = 1'b0;
        irq_out          = 1'b0;
        status_wr        = 1'b0;

        if (item_en) begin
            unique case (item.func)
                vmb_pkg::FUNC_READ: begin
                    rdata = ({32'd0, word} << {item.offset[vmb_pkg::LANE_SEL_W-1:0], 3'b000})
                            & vmb_pkg::BUS_MASK;
                end
                vmb_pkg::FUNC_WRITE: begin
                    case (base)
                        vmb_pkg::OFS_DEV_FSEL: begin
                            dev_fsel_next = vmb_pkg::lane32(dev_fsel_reg, lane, item.write_byte);
                        end
                        vmb_pkg::OFS_DRV_FEAT: begin
                            drv_feat_next[drv_fsel_reg[0]] =
                                vmb_pkg::lane32(drv_feat_reg[drv_fsel_reg[0]], lane,
                                                item.write_byte);
                        end
                        vmb_pkg::OFS_DRV_FSEL: begin
                            drv_fsel_next = vmb_pkg::lane32(drv_fsel_reg, lane, item.write_byte);
                        end
                        vmb_pkg::OFS_QUEUE_SEL: begin
                            qsel_next = vmb_pkg::lane32(qsel_reg, lane, item.write_byte);
                        end
                        vmb_pkg::OFS_QUEUE_NUM: begin
                            qsize_next = (qsize_merged > 32'(vmb_pkg::QUEUE_MAX)) ?
                                         vmb_pkg::QSZ_W'(vmb_pkg::QUEUE_MAX) :
                                         qsize_merged[vmb_pkg::QSZ_W-1:0];
                        end
                        vmb_pkg::OFS_QUEUE_READY: begin
                            // only bit 0 exists, so only lane 0 changes it
                            if (lane == 2'd0) qready_next = item.write_byte[0];
                        end
                        vmb_pkg::OFS_NOTIFY: begin
                            notify = (lane == 2'd0) && usable;
                        end
                        vmb_pkg::OFS_IRQ_ACK: begin
                            if (lane == 2'd0 && item.write_byte[0]) irq_next = 1'b0;
                        end
                        vmb_pkg::OFS_STATUS: begin
                            status_next = vmb_pkg::lane32(status_reg, lane, item.write_byte);
                            status_wr   = 1'b1;
                        end
                        vmb_pkg::OFS_DESC_LO, vmb_pkg::OFS_DESC_HI: begin
                            desc_next = vmb_pkg::lane64(desc_reg, item.offset[2:0],
                                                        item.write_byte);
                        end
                        vmb_pkg::OFS_AVAIL_LO, vmb_pkg::OFS_AVAIL_HI: begin
                            avail_next = vmb_pkg::lane64(avail_reg, item.offset[2:0],
                                                         item.write_byte);
                        end
                        vmb_pkg::OFS_USED_LO, vmb_pkg::OFS_USED_HI: begin
                            used_next = vmb_pkg::lane64(used_reg, item.offset[2:0],
                                                        item.write_byte);
                        end
                        default: ;
                    endcase
                end
                vmb_pkg::FUNC_DONE: begin
                    irq_next = 1'b1;
                    irq_out  = 1'b1;
                end
                default: ;
            endcase

            // Status written to zero: device reset
            if (status_wr && status_next == 32'd0) begin
                dev_fsel_next    = 32'd0;
                drv_fsel_next    = 32'd0;
                drv_feat_next[0] = 32'd0;
                drv_feat_next[1] = 32'd0;
                qsel_next        = 32'd0;
                qsize_next       = '0;
                qready_next      = 1'b0;
                irq_next         = 1'b0;
                desc_next        = 64'd0;
                avail_next       = 64'd0;
                used_next        = 64'd0;
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_fsel_reg    <= 32'd0;
            drv_fsel_reg    <= 32'd0;
            drv_feat_reg[0] <= 32'd0;
            drv_feat_reg[1] <= 32'd0;
            qsel_reg        <= 32'd0;
            qsize_reg       <= '0;
            qready_reg      <= 1'b0;
            status_reg      <= 32'd0;
            irq_reg         <= 1'b0;
            desc_reg        <= 64'd0;
            avail_reg       <= 64'd0;
            used_reg        <= 64'd0;
        end else begin
            dev_fsel_reg    <= dev_fsel_next;
            drv_fsel_reg    <= drv_fsel_next;
            drv_feat_reg[0] <= drv_feat_next[0];
            drv_feat_reg[1] <= drv_feat_next[1];
            qsel_reg        <= qsel_next;
            qsize_reg       <= qsize_next;
            qready_reg      <= qready_next;
            status_reg      <= status_next;
            irq_reg         <= irq_next;
            desc_reg        <= desc_next;
            avail_reg       <= avail_next;
            used_reg        <= used_next;
        end
    end

    // Result item, effective queue size taken after this item's update
    assign result.read_data      = rdata;
    assign result.notify_request = notify;
    assign result.queue_size     = (qsize_next != '0) ? 4'(qsize_next) :
                                   4'(vmb_pkg::QUEUE_MAX);
    assign result.irq_raise      = irq_out;

endmodule

// ===== rtl/virtio_mmio_block_registers.sv =====
// virtio_mmio_block_registers: top level of the virtio-mmio block register front end.
// The result is registered in the cycle after accept. Throughput: one item per cycle
// unless the output register is full and m_ready is low; decode and lane update
// finish in the accept cycle, and the output register takes a new result while the
// old one leaves. Reset: aresetn low (synchronous) clears all device registers,
// disk size and m_valid; no clearing pass. Depends on vmb_pkg, vmb_cfg, vmb_core.
module virtio_mmio_block_registers (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  vmb_pkg::in_item_t              s_item,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output vmb_pkg::out_item_t             m_item,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vmb_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [63:0]                    pwdata,
    output logic [63:0]                    prdata,
    output logic                           pready
);

    logic [vmb_pkg::DISK_W-1:0] disk_bytes;
    logic                       accept;
    vmb_pkg::out_item_t         result;
    vmb_pkg::out_item_t         out_reg;
    logic                       out_valid_reg;

    vmb_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .disk_bytes (disk_bytes)
    );

    // Take a new item whenever the output register is empty or draining
    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    vmb_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_en    (accept),
        .item       (s_item),
        .disk_bytes (disk_bytes),
        .result     (result)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

// ===== sim/virtio_mmio_block_registers_tb.sv =====
// Self-checking testbench for the virtio-mmio block device register front end.
// Predicts every result item from a local register model and checks each item out.
// Depends on vmb_pkg and virtio_mmio_block_registers.
module virtio_mmio_block_registers_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [vmb_pkg::CFG_ADDR_W-1:0] DISK_ADDR =
        vmb_pkg::CFG_ADDR_W'(8 * vmb_pkg::CFG_DISK_BYTES);
    localparam logic [7:0] DRIVER_OK_BIT = 8'(1 << vmb_pkg::STATUS_DRIVER_OK);

    typedef enum {SINK_STEADY, SINK_COIN, SINK_RARE_STALL, SINK_SLOW} sink_mode_t;

    logic                           aclk    = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    vmb_pkg::in_item_t              s_item  = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    vmb_pkg::out_item_t             m_item;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [vmb_pkg::CFG_ADDR_W-1:0] paddr   = '0;
    logic [63:0]                    pwdata  = '0;
    logic [63:0]                    prdata;
    logic                           pready;

    // Local copy of the device registers and the disk size
    logic [vmb_pkg::DISK_W-1:0] disk_len = '0;
    logic [31:0]       dev_fsel, drv_fsel, qsel, dev_status;
    logic [31:0]       drv_features [2];
    logic [3:0]        qsize_reg;
    logic              ready_flag, irq_pending;
    logic [63:0]       desc_ptr, avail_addr, used_addr;

    vmb_pkg::out_item_t expected_results [$];
    int        fail_count  = 0;
    int        items_sent  = 0;
    int        burst_left  = 0;
    bit        hold_start  = 1'b0;

    logic [11:0] reg_offsets [0:23] = '{
        vmb_pkg::OFS_MAGIC, vmb_pkg::OFS_VERSION, vmb_pkg::OFS_DEVICE_ID,
        vmb_pkg::OFS_VENDOR, vmb_pkg::OFS_DEV_FEAT, vmb_pkg::OFS_DEV_FSEL,
        vmb_pkg::OFS_DRV_FEAT, vmb_pkg::OFS_DRV_FSEL, vmb_pkg::OFS_QUEUE_SEL,
        vmb_pkg::OFS_QUEUE_MAX, vmb_pkg::OFS_QUEUE_NUM, vmb_pkg::OFS_QUEUE_READY,
        vmb_pkg::OFS_NOTIFY, vmb_pkg::OFS_IRQ_STATUS, vmb_pkg::OFS_IRQ_ACK,
        vmb_pkg::OFS_STATUS, vmb_pkg::OFS_DESC_LO, vmb_pkg::OFS_DESC_HI,
        vmb_pkg::OFS_AVAIL_LO, vmb_pkg::OFS_AVAIL_HI, vmb_pkg::OFS_USED_LO,
        vmb_pkg::OFS_USED_HI, vmb_pkg::OFS_CAP_LO, vmb_pkg::OFS_CAP_HI};

    virtio_mmio_block_registers DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Register model
    // ---------------------------------------------------------------
    function automatic void clear_device_regs();
        dev_fsel        = '0;
        drv_fsel        = '0;
        drv_features[0] = '0;
        drv_features[1] = '0;
        qsel            = '0;
        qsize_reg       = '0;
        ready_flag      = 1'b0;
        dev_status      = '0;
        irq_pending     = 1'b0;
        desc_ptr        = '0;
        avail_addr      = '0;
        used_addr       = '0;
    endfunction

    function automatic logic [31:0] set_byte32(logic [31:0] word, logic [1:0] lane,
                                               logic [7:0] b);
        logic [31:0] r;
        r = word;
        r[lane*8 +: 8] = b;
        return r;
    endfunction

    function automatic logic queue_usable();
        return disk_len != 0 && qsel == 0 && ready_flag
            && dev_status[vmb_pkg::STATUS_DRIVER_OK]
            && desc_ptr != 0 && avail_addr != 0 && used_addr != 0;
    endfunction

    // 32-bit value seen by a read of one register word
    function automatic logic [31:0] register_word(logic [11:0] base);
        logic [38:0] sectors;
        sectors = disk_len[vmb_pkg::DISK_W-1:vmb_pkg::SECTOR_SHIFT];
        case (base)
            vmb_pkg::OFS_MAGIC:   return vmb_pkg::MAGIC_WORD;
            vmb_pkg::OFS_VERSION: return vmb_pkg::VERSION_WORD;
            vmb_pkg::OFS_VENDOR:  return vmb_pkg::VENDOR_WORD;
            default: ;
        endcase
        // without a disk everything else reads as zero
        if (disk_len == 0) return '0;
        case (base)
            vmb_pkg::OFS_DEVICE_ID:   return vmb_pkg::DEVICE_ID;
            vmb_pkg::OFS_QUEUE_MAX:   return (qsel == 0) ? 32'(vmb_pkg::QUEUE_MAX) : 32'd0;
            vmb_pkg::OFS_QUEUE_READY: return {31'd0, ready_flag};
            vmb_pkg::OFS_IRQ_STATUS:  return {31'd0, irq_pending};
            vmb_pkg::OFS_STATUS:      return dev_status;
            vmb_pkg::OFS_CAP_LO:      return sectors[31:0];
            vmb_pkg::OFS_CAP_HI:      return {25'd0, sectors[38:32]};
            default:                  return '0;
        endcase
    endfunction

    // Apply one bus access to the model and return the result item it produces
    function automatic vmb_pkg::out_item_t register_access(vmb_pkg::in_item_t it);
        vmb_pkg::out_item_t r;
        logic [11:0] base;
        logic [1:0]  lane;
        logic [31:0] merged;
        int          pos;
        r    = '0;
        base = {it.offset[11:2], 2'b00};
        lane = it.offset[1:0];
        pos  = {base[2], lane} * 8;
        case (it.func)
            vmb_pkg::FUNC_READ: begin
                r.read_data = ({32'd0, register_word(base)}
                               << (8 * (it.offset % vmb_pkg::BUS_BYTES)))
                              & vmb_pkg::BUS_MASK;
            end
            vmb_pkg::FUNC_WRITE: begin
                case (base)
                    vmb_pkg::OFS_DEV_FSEL:
                        dev_fsel = set_byte32(dev_fsel, lane, it.write_byte);
                    vmb_pkg::OFS_DRV_FEAT:
                        drv_features[drv_fsel[0]] =
                            set_byte32(drv_features[drv_fsel[0]], lane, it.write_byte);
                    vmb_pkg::OFS_DRV_FSEL:
                        drv_fsel = set_byte32(drv_fsel, lane, it.write_byte);
                    vmb_pkg::OFS_QUEUE_SEL:
                        qsel = set_byte32(qsel, lane, it.write_byte);
                    vmb_pkg::OFS_QUEUE_NUM: begin
                        merged = set_byte32({28'd0, qsize_reg}, lane, it.write_byte);
                        qsize_reg = (merged > vmb_pkg::QUEUE_MAX) ?
                                    4'(vmb_pkg::QUEUE_MAX) : merged[3:0];
                    end
                    // only bit 0 of the ready flag exists
                    vmb_pkg::OFS_QUEUE_READY:
                        if (lane == 0) ready_flag = it.write_byte[0];
                    vmb_pkg::OFS_NOTIFY:
                        r.notify_request = (lane == 0) && queue_usable();
                    vmb_pkg::OFS_IRQ_ACK:
                        if (lane == 0 && it.write_byte[0]) irq_pending = 1'b0;
                    vmb_pkg::OFS_STATUS: begin
                        dev_status = set_byte32(dev_status, lane, it.write_byte);
                        if (dev_status == 0) clear_device_regs();
                    end
                    vmb_pkg::OFS_DESC_LO, vmb_pkg::OFS_DESC_HI:
                        desc_ptr[pos +: 8] = it.write_byte;
                    vmb_pkg::OFS_AVAIL_LO, vmb_pkg::OFS_AVAIL_HI:
                        avail_addr[pos +: 8] = it.write_byte;
                    vmb_pkg::OFS_USED_LO, vmb_pkg::OFS_USED_HI:
                        used_addr[pos +: 8] = it.write_byte;
                    default: ;
                endcase
            end
            vmb_pkg::FUNC_DONE: begin
                irq_pending = 1'b1;
                r.irq_raise = 1'b1;
            end
            default: ;
        endcase
        r.queue_size = (qsize_reg != 0) ? qsize_reg : 4'(vmb_pkg::QUEUE_MAX);
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        vmb_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result item %h", $time, m_item);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("read_data", want.read_data, m_item.read_data);
                check_field("notify_request", 64'(want.notify_request),
                            64'(m_item.notify_request));
                check_field("queue_size", 64'(want.queue_size), 64'(m_item.queue_size));
                check_field("irq_raise", 64'(want.irq_raise), 64'(m_item.irq_raise));
            end
        end
    end

    // Result side ready: random stall patterns, plus a long hold on request
    initial begin : result_sink
        sink_mode_t mode;
        int         mode_left;
        int         hold_left;
        mode      = SINK_STEADY;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_start) begin
                hold_start = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = sink_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(8, 60);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    SINK_STEADY:     m_ready <= 1'b1;
                    SINK_COIN:       m_ready <= ($urandom_range(0, 1) == 1);
                    SINK_RARE_STALL: m_ready <= ($urandom_range(0, 7) != 0);
                    default:         m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic vmb_pkg::in_item_t access(vmb_pkg::func_t f, logic [11:0] ofs,
                                                 logic [7:0] b);
        vmb_pkg::in_item_t it;
        it.func       = f;
        it.offset     = ofs;
        it.write_byte = b;
        return it;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [11:0] pick_offset();
        if ($urandom_range(0, 1) == 0)
            return reg_offsets[$urandom_range(0, 23)] | 12'($urandom_range(0, 3));
        return 12'($urandom_range(0, 4095));
    endfunction

    // Send one item in bursts with random gaps; predict it once accepted
    task automatic send_item(vmb_pkg::in_item_t it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(register_access(it));
        items_sent++;
    endtask

    // Drop a step now and then to break the driver bring-up order
    task automatic maybe_send(vmb_pkg::in_item_t it);
        if ($urandom_range(0, 11) != 0) send_item(it);
    endtask

    task automatic wait_idle();
        int waited;
        s_valid <= 1'b0;
        burst_left = 0;
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_results.size() != 0) begin
            $display("%0t: %0d result items never arrived", $time, expected_results.size());
            fail_count++;
            expected_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the disk size and read it back
    task automatic cfg_write(logic [63:0] value);
        logic [63:0] rd;
        paddr   <= DISK_ADDR;
        pwdata  <= value;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        disk_len = value[vmb_pkg::DISK_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        psel    <= 1'b1;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field("disk_bytes readback", {16'd0, disk_len}, rd);
    endtask

    // Typical driver bring-up with random content, then queue traffic
    task automatic drive_bringup();
        int ops;
        int lane_pick;
        if ($urandom_range(0, 3) == 0)
            for (int k = 3; k >= 0; k--)
                maybe_send(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_STATUS | 12'(k), 8'h00));
        maybe_send(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_STATUS, pick_byte() | 8'h01));
        maybe_send(access(vmb_pkg::FUNC_WRITE,
                          vmb_pkg::OFS_DEV_FSEL | 12'($urandom_range(0, 3)), pick_byte()));
        maybe_send(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_DRV_FSEL,
                          8'($urandom_range(0, 1))));
        maybe_send(access(vmb_pkg::FUNC_WRITE,
                          vmb_pkg::OFS_DRV_FEAT | 12'($urandom_range(0, 3)), pick_byte()));
        if ($urandom_range(0, 7) == 0)
            maybe_send(access(vmb_pkg::FUNC_WRITE,
                              vmb_pkg::OFS_QUEUE_SEL | 12'($urandom_range(0, 3)),
                              pick_byte()));
        else
            maybe_send(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_QUEUE_SEL, 8'h00));
        maybe_send(access(vmb_pkg::FUNC_READ, vmb_pkg::OFS_QUEUE_MAX, pick_byte()));
        if ($urandom_range(0, 5) == 0)
            maybe_send(access(vmb_pkg::FUNC_WRITE,
                              vmb_pkg::OFS_QUEUE_NUM | 12'($urandom_range(0, 3)),
                              pick_byte()));
        else
            maybe_send(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_QUEUE_NUM,
                              8'($urandom_range(0, 12))));
        // ring addresses: one to three lanes each
        repeat ($urandom_range(1, 3))
            maybe_send(access(vmb_pkg::FUNC_WRITE,
                              vmb_pkg::OFS_DESC_LO | 12'($urandom_range(0, 7)), pick_byte()));
        repeat ($urandom_range(1, 3))
            maybe_send(access(vmb_pkg::FUNC_WRITE,
                              vmb_pkg::OFS_AVAIL_LO | 12'($urandom_range(0, 7)),
                              pick_byte()));
        repeat ($urandom_range(1, 3))
            maybe_send(access(vmb_pkg::FUNC_WRITE,
                              vmb_pkg::OFS_USED_LO | 12'($urandom_range(0, 7)), pick_byte()));
        maybe_send(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_QUEUE_READY,
                          ($urandom_range(0, 7) == 0) ? pick_byte() : 8'h01));
        maybe_send(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_STATUS,
                          pick_byte() | DRIVER_OK_BIT));
        // queue traffic: notifies, completions, acks and reads
        ops = $urandom_range(4, 14);
        repeat (ops) begin
            lane_pick = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
            case ($urandom_range(0, 5))
                0, 1: maybe_send(access(vmb_pkg::FUNC_WRITE,
                                        vmb_pkg::OFS_NOTIFY | 12'(lane_pick), pick_byte()));
                2:    maybe_send(access(vmb_pkg::FUNC_DONE, pick_offset(), pick_byte()));
                3:    maybe_send(access(vmb_pkg::FUNC_WRITE,
                                        vmb_pkg::OFS_IRQ_ACK | 12'(lane_pick), pick_byte()));
                default: maybe_send(access(vmb_pkg::FUNC_READ,
                                           reg_offsets[$urandom_range(0, 23)]
                                           | 12'($urandom_range(0, 3)), pick_byte()));
            endcase
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // No disk: only identification words read back, notify stays quiet
    task automatic test_no_disk();
        wait_idle();
        cfg_write(64'd0);
        send_item(access(vmb_pkg::FUNC_READ, vmb_pkg::OFS_MAGIC, 8'h00));
        send_item(access(vmb_pkg::FUNC_READ, vmb_pkg::OFS_DEVICE_ID, 8'h00));
        send_item(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_STATUS, 8'hff));
        send_item(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_QUEUE_READY, 8'h01));
        send_item(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_DESC_LO, 8'h01));
        send_item(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_AVAIL_HI | 12'd3, 8'hff));
        send_item(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_USED_LO, 8'h80));
        send_item(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_NOTIFY, 8'h00));
        send_item(access(vmb_pkg::FUNC_NOP, 12'hfff, 8'hff));
    endtask

    // Largest disk: every special register behavior once
    task automatic test_directed_registers();
        wait_idle();
        cfg_write({16'd0, {vmb_pkg::DISK_W{1'b1}}});
        send_item(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_NOTIFY, 8'h00));  // queue usable
        // upper lane ignored
        send_item(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_NOTIFY | 12'd3, 8'h00));
        // top of the bus word
        send_item(access(vmb_pkg::FUNC_READ, vmb_pkg::OFS_CAP_HI | 12'd3, 8'h00));
        send_item(access(vmb_pkg::FUNC_READ, vmb_pkg::OFS_CAP_LO, 8'h00));
        send_item(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_QUEUE_NUM, 8'hff));   // clamped
        send_item(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_QUEUE_NUM, 8'h03));
        send_item(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_QUEUE_READY | 12'd1, 8'h00));
        send_item(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_QUEUE_SEL | 12'd2, 8'h01));
        send_item(access(vmb_pkg::FUNC_READ, vmb_pkg::OFS_QUEUE_MAX, 8'h00));
        send_item(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_NOTIFY, 8'h00));  // wrong queue
        send_item(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_QUEUE_SEL | 12'd2, 8'h00));
        send_item(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_DRV_FSEL, 8'h01));
        send_item(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_DRV_FEAT | 12'd1, 8'hab));
        send_item(access(vmb_pkg::FUNC_DONE, 12'h000, 8'h00));
        // no clear
        send_item(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_IRQ_ACK | 12'd1, 8'h01));
        send_item(access(vmb_pkg::FUNC_READ, vmb_pkg::OFS_IRQ_STATUS, 8'h00));
        send_item(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_IRQ_ACK, 8'h01));
        send_item(access(vmb_pkg::FUNC_READ, vmb_pkg::OFS_IRQ_STATUS | 12'd1, 8'h00));
        // full register reset
        send_item(access(vmb_pkg::FUNC_WRITE, vmb_pkg::OFS_STATUS, 8'h00));
        send_item(access(vmb_pkg::FUNC_READ, vmb_pkg::OFS_QUEUE_READY, 8'h00));
    endtask

    // Result side holds off while items keep coming
    task automatic test_output_stall();
        wait_idle();
        hold_start = 1'b1;
        burst_left = 40;
        repeat (30)
            send_item(access(vmb_pkg::func_t'($urandom_range(0, 2)), pick_offset(),
                             pick_byte()));
    endtask

    task automatic test_random_traffic(logic [63:0] disk_cfg, int count);
        int start;
        wait_idle();
        cfg_write(disk_cfg);
        start = items_sent;
        while (items_sent - start < count) begin
            if ($urandom_range(0, 9) < 6)
                drive_bringup();
            else
                repeat ($urandom_range(1, 8))
                    send_item(access(vmb_pkg::func_t'($urandom_range(0, 3)), pick_offset(),
                                     pick_byte()));
        end
    endtask

    // ---------------------------------------------------------------
    // Main flow
    // ---------------------------------------------------------------
    initial begin
        clear_device_regs();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        disk_len = '0;
        clear_device_regs();

        test_no_disk();
        test_directed_registers();
        test_output_stall();
        test_random_traffic({$urandom, $urandom}, 220);
        test_random_traffic(64'd511, 220);           // present, under one sector
        test_random_traffic(64'hdead_ffff_ffff_ffff, 220);
        test_random_traffic(64'd512, 220);
        test_random_traffic(64'd0, 220);
        wait_idle();

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
